// ----- design/mbet_pkg.sv -----
// Shared types, register map and constants for the Mandelbrot escape-time block.
package mbet_pkg;

    // Largest pixel index is IMAGE_DIM - 1; larger indices saturate.
    localparam int unsigned IMAGE_DIM = 8192;

    localparam int unsigned IDX_W   = 13;
    localparam int unsigned ITER_W  = 16;
    localparam int unsigned FRAC_W  = 17;
    localparam int unsigned ADDR_W  = 5;

    // Register reset values (Q4.28 for coordinates).
    localparam logic [31:0] RST_ORIGIN_RE = 32'(-563714458);
    localparam logic [31:0] RST_ORIGIN_IM = 32'(-348966093);
    localparam logic [30:0] RST_STEP_RE   = 31'd101581;
    localparam logic [30:0] RST_STEP_IM   = 31'd85197;
    localparam logic [15:0] RST_LIMIT     = 16'd1000;

    typedef enum logic [2:0] {
        REG_ORIGIN_RE = 3'd0,
        REG_ORIGIN_IM = 3'd1,
        REG_STEP_RE   = 3'd2,
        REG_STEP_IM   = 3'd3,
        REG_LIMIT     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic [FRAC_W-1:0] fraction;
        logic              in_set;
    } t_pix_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_CRE,
        ST_MUL_CIM,
        ST_C_SUM,
        ST_SQX,
        ST_SQY,
        ST_XY,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } t_state;

    function automatic logic [IDX_W-1:0] sat_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        res = idx;
        if (32'(idx) >= IMAGE_DIM) begin
            res = IDX_W'(IMAGE_DIM - 1);
        end
        return res;
    endfunction

endpackage

// ----- design/mbet_frac_div.sv -----
// Restoring divider: floor(count * 65536 / limit) for count <= limit, one bit per cycle.
module mbet_frac_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mbet_pkg::ITER_W-1:0]        i_count,
    input  logic [mbet_pkg::ITER_W-1:0]        i_limit,
    output logic                               o_done,
    output logic [mbet_pkg::FRAC_W-1:0]        o_quot
);

    localparam int unsigned QW      = mbet_pkg::FRAC_W;
    localparam int unsigned STEP_W  = $clog2(QW);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [QW-1:0]     r_rem;
    logic [QW-1:0]     r_quot;

    logic              ge;
    logic [QW-1:0]     rem_sub;

    always_comb begin
        ge      = r_rem >= QW'(i_limit);
        rem_sub = ge ? (r_rem - QW'(i_limit)) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below limit after each subtract, so the shift fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= QW'(i_count);
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {rem_sub[QW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- design/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time top level: config registers, sequencer and one shared multiplier.
// Sequence, transaction in to o_out_valid: setup states ST_MUL_CRE, ST_MUL_CIM and ST_C_SUM,
// then ST_SQX, ST_SQY, ST_XY and ST_UPD per iteration; the exit test in ST_SQX or, when
// |z|^2 >= 4 ends the loop, in ST_XY; then the fraction divider, ST_OUT and the output
// register, which waits under output stall. One pixel at a time: o_in_stall is high until the result loads.
// Synchronous active-low reset clears control state and restores register defaults.
module mandelbrot_escape_time #(
    parameter int FRAC_BITS = 28
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mbet_pkg::t_pix_in                 i_pix_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mbet_pkg::t_pix_out                o_pix_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbet_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // multiplier operand width and z / c register width
    localparam int MW = (FRAC_BITS + 1 > 31) ? FRAC_BITS + 1 : 31;
    localparam int PW = 2 * MW;
    localparam int ZW = (FRAC_BITS + 5 > 47) ? FRAC_BITS + 5 : 47;

    localparam logic [ZW-1:0] TWO     = ZW'(1) << (FRAC_BITS + 1);
    localparam logic [PW:0]   ESC_LIM = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

    // configuration registers
    logic [31:0] r_origin_re;
    logic [31:0] r_origin_im;
    logic [30:0] r_step_re;
    logic [30:0] r_step_im;
    logic [15:0] r_limit;

    logic [2:0]  reg_idx;
    logic        cfg_wr;

    assign reg_idx = paddr[mbet_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= mbet_pkg::RST_ORIGIN_RE;
            r_origin_im <= mbet_pkg::RST_ORIGIN_IM;
            r_step_re   <= mbet_pkg::RST_STEP_RE;
            r_step_im   <= mbet_pkg::RST_STEP_IM;
            r_limit     <= mbet_pkg::RST_LIMIT;
        end else if (cfg_wr) begin
            case (reg_idx)
                mbet_pkg::REG_ORIGIN_RE: r_origin_re <= pwdata;
                mbet_pkg::REG_ORIGIN_IM: r_origin_im <= pwdata;
                mbet_pkg::REG_STEP_RE:   r_step_re   <= pwdata[30:0];
                mbet_pkg::REG_STEP_IM:   r_step_im   <= pwdata[30:0];
                mbet_pkg::REG_LIMIT:     r_limit     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mbet_pkg::REG_ORIGIN_RE: prdata = r_origin_re;
            mbet_pkg::REG_ORIGIN_IM: prdata = r_origin_im;
            mbet_pkg::REG_STEP_RE:   prdata = 32'(r_step_re);
            mbet_pkg::REG_STEP_IM:   prdata = 32'(r_step_im);
            mbet_pkg::REG_LIMIT:     prdata = 32'(r_limit);
            default:                 prdata = '0;
        endcase
    end

    // sequencer and datapath
    mbet_pkg::t_state            r_state, n_state;
    logic [mbet_pkg::IDX_W-1:0]  r_col, n_col;
    logic [mbet_pkg::IDX_W-1:0]  r_row, n_row;
    logic [ZW-1:0]               r_cre, n_cre;
    logic [ZW-1:0]               r_cim, n_cim;
    logic [ZW-1:0]               r_x, n_x;
    logic [ZW-1:0]               r_y, n_y;
    logic [PW-1:0]               r_prod;
    logic [PW-1:0]               r_sqx, n_sqx;
    logic [PW-1:0]               r_sqy, n_sqy;
    logic                        r_neg, n_neg;
    logic [15:0]                 r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    mbet_pkg::t_pix_out          r_out, n_out;

    logic [15:0]   limit_eff;
    logic [ZW-1:0] ax, ay;
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic [PW:0]   sq_sum;
    logic [ZW-1:0] xy_t;
    logic          out_free;
    logic          in_acc;
    logic          div_start;
    logic          div_done;
    logic [mbet_pkg::FRAC_W-1:0] div_quot;

    assign limit_eff = (r_limit == 16'd0) ? 16'd1 : r_limit;
    assign ax        = r_x[ZW-1] ? (ZW'(0) - r_x) : r_x;
    assign ay        = r_y[ZW-1] ? (ZW'(0) - r_y) : r_y;
    assign sq_sum    = {1'b0, r_sqx} + {1'b0, r_prod};
    assign xy_t      = ZW'(r_prod >> (FRAC_BITS - 1));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_acc    = i_in_valid && (r_state == mbet_pkg::ST_IDLE);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            mbet_pkg::ST_MUL_CRE: begin
                mul_a = MW'(r_col);
                mul_b = MW'(r_step_re);
            end
            mbet_pkg::ST_MUL_CIM: begin
                mul_a = MW'(r_row);
                mul_b = MW'(r_step_im);
            end
            mbet_pkg::ST_SQX: begin
                mul_a = ax[MW-1:0];
                mul_b = ax[MW-1:0];
            end
            mbet_pkg::ST_SQY: begin
                mul_a = ay[MW-1:0];
                mul_b = ay[MW-1:0];
            end
            mbet_pkg::ST_XY: begin
                mul_a = ax[MW-1:0];
                mul_b = ay[MW-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_cre       = r_cre;
        n_cim       = r_cim;
        n_x         = r_x;
        n_y         = r_y;
        n_sqx       = r_sqx;
        n_sqy       = r_sqy;
        n_neg       = r_neg;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mbet_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_col   = mbet_pkg::sat_index(i_pix_in.column);
                    n_row   = mbet_pkg::sat_index(i_pix_in.row);
                    n_state = mbet_pkg::ST_MUL_CRE;
                end
            end
            mbet_pkg::ST_MUL_CRE: begin
                n_state = mbet_pkg::ST_MUL_CIM;
            end
            mbet_pkg::ST_MUL_CIM: begin
                n_cre   = {{(ZW-32){r_origin_re[31]}}, r_origin_re} + ZW'(r_prod);
                n_state = mbet_pkg::ST_C_SUM;
            end
            mbet_pkg::ST_C_SUM: begin
                n_cim   = {{(ZW-32){r_origin_im[31]}}, r_origin_im} + ZW'(r_prod);
                n_x     = '0;
                n_y     = '0;
                n_count = '0;
                n_state = mbet_pkg::ST_SQX;
            end
            mbet_pkg::ST_SQX: begin
                // loop exit on limit or on a component already at magnitude 2 or more
                if (r_count >= limit_eff || ax >= TWO || ay >= TWO) begin
                    div_start = 1'b1;
                    n_state   = mbet_pkg::ST_DIV;
                end else begin
                    n_state = mbet_pkg::ST_SQY;
                end
            end
            mbet_pkg::ST_SQY: begin
                n_sqx   = r_prod;
                n_state = mbet_pkg::ST_XY;
            end
            mbet_pkg::ST_XY: begin
                // exact |z|^2 >= 4 on the full squares
                if (sq_sum >= ESC_LIM) begin
                    div_start = 1'b1;
                    n_state   = mbet_pkg::ST_DIV;
                end else begin
                    n_sqy   = r_prod;
                    n_neg   = r_x[ZW-1] ^ r_y[ZW-1];
                    n_state = mbet_pkg::ST_UPD;
                end
            end
            mbet_pkg::ST_UPD: begin
                n_x     = ZW'(r_sqx >> FRAC_BITS) - ZW'(r_sqy >> FRAC_BITS) + r_cre;
                n_y     = (r_neg ? (ZW'(0) - xy_t) : xy_t) + r_cim;
                n_count = r_count + 16'd1;
                n_state = mbet_pkg::ST_SQX;
            end
            mbet_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = mbet_pkg::ST_OUT;
                end
            end
            mbet_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out.iterations = r_count;
                    n_out.fraction   = div_quot;
                    n_out.in_set     = (r_count == limit_eff);
                    n_out_valid      = 1'b1;
                    n_state          = mbet_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mbet_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbet_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col  <= n_col;
        r_row  <= n_row;
        r_cre  <= n_cre;
        r_cim  <= n_cim;
        r_x    <= n_x;
        r_y    <= n_y;
        r_prod <= mul_p;
        r_sqx  <= n_sqx;
        r_sqy  <= n_sqy;
        r_neg  <= n_neg;
        r_out  <= n_out;
    end

    mbet_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_count (r_count),
        .i_limit (limit_eff),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_stall  = (r_state != mbet_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pix_out   = r_out;

endmodule

// ----- design/mbet_checker.sv -----
// Port-level checker for the Mandelbrot escape-time block, bound to the top level.
module mbet_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mbet_pkg::t_pix_out o_pix_out,
    input logic               pready
);

    // one pixel in flight: a taken transaction holds off the next one
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous pixel in progress");

    // full fraction exactly when the limit was reached
    a_inset_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pix_out.in_set == (o_pix_out.fraction == 17'h10000)))
        else $error("in_set and fraction disagree");

    // fraction never exceeds 1.0
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_pix_out.fraction[16] && (o_pix_out.fraction[15:0] != 16'd0)))
        else $error("fraction above 1.0");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_pix_out)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind mandelbrot_escape_time mbet_checker u_mbet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pix_out   (o_pix_out),
    .pready      (pready)
);
